### hw/rtl/hutc_pkg.sv
package hutc_pkg;

    localparam int RAW_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 28;
    localparam int BASE_W  = 29;
    localparam int NUM_W   = 41;
    localparam int MAG_W   = 40;
    localparam int DEN_W   = 23;
    localparam int DMAG_W  = 22;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [OUT_W-1:0] Q8_MAX = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] Q8_MIN = 24'h800000;

    typedef enum logic [IDX_W-1:0] {
        REG_TEMP_LOW_PT  = 3'd0,
        REG_TEMP_HIGH_PT = 3'd1,
        REG_TEMP_LOW_RAW = 3'd2,
        REG_TEMP_HIGH_RAW = 3'd3,
        REG_HUM_LOW_PT   = 3'd4,
        REG_HUM_HIGH_PT  = 3'd5,
        REG_HUM_LOW_RAW  = 3'd6,
        REG_HUM_HIGH_RAW = 3'd7
    } reg_idx_t;

    localparam logic CMD_TEMP = 1'b0;

    // division job handed from front to back
    typedef struct packed {
        logic              kind;
        logic              err;
        logic              neg;
        logic [MAG_W-1:0]  num_mag;
        logic [DMAG_W-1:0] den_mag;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### hw/rtl/hutc_front.sv
module hutc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hutc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hutc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,
    input  logic                        s_tuser,
    input  logic                        q_full,
    output logic                        push,
    output hutc_pkg::job_t              job
);
    import hutc_pkg::*;

    logic [9:0]        t_lo_pt_reg, t_hi_pt_reg;
    logic [7:0]        h_lo_pt_reg, h_hi_pt_reg;
    logic [RAW_W-1:0]  t_lo_raw_reg, t_hi_raw_reg, h_lo_raw_reg, h_hi_raw_reg;

    logic                      v1_reg, v2_reg, adv;
    logic                      kind1_reg;
    logic signed [DIFF_W-1:0]  d1_reg;
    logic signed [PROD_W-1:0]  p1_reg, p2_reg;
    job_t                      job_reg, job_next;

    logic signed [DIFF_W-1:0]  x, x0, x1, d, xd;
    logic signed [10:0]        y0, y1, dy;
    logic signed [BASE_W-1:0]  base;
    logic signed [NUM_W-1:0]   be, de, num;
    logic signed [DEN_W-1:0]   dd, den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_lo_pt_reg  <= '0;
            t_hi_pt_reg  <= '0;
            t_lo_raw_reg <= '0;
            t_hi_raw_reg <= 16'd1;
            h_lo_pt_reg  <= '0;
            h_hi_pt_reg  <= '0;
            h_lo_raw_reg <= '0;
            h_hi_raw_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TEMP_LOW_PT:   t_lo_pt_reg  <= cfg_data[9:0];
                REG_TEMP_HIGH_PT:  t_hi_pt_reg  <= cfg_data[9:0];
                REG_TEMP_LOW_RAW:  t_lo_raw_reg <= cfg_data;
                REG_TEMP_HIGH_RAW: t_hi_raw_reg <= cfg_data;
                REG_HUM_LOW_PT:    h_lo_pt_reg  <= cfg_data[7:0];
                REG_HUM_HIGH_PT:   h_hi_pt_reg  <= cfg_data[7:0];
                REG_HUM_LOW_RAW:   h_lo_raw_reg <= cfg_data;
                REG_HUM_HIGH_RAW:  h_hi_raw_reg <= cfg_data;
            endcase
        end
    end

    assign adv      = !(v2_reg && q_full);
    assign s_tready = adv;
    assign push     = v2_reg && !q_full;
    assign job      = job_reg;

    // stage 1: differences and products
    always_comb
    begin
        x = DIFF_W'($signed(s_tdata));
        if (s_tuser == CMD_TEMP)
        begin
            y0 = $signed({1'b0, t_lo_pt_reg});
            y1 = $signed({1'b0, t_hi_pt_reg});
            x0 = DIFF_W'($signed(t_lo_raw_reg));
            x1 = DIFF_W'($signed(t_hi_raw_reg));
        end
        else
        begin
            y0 = $signed({3'b000, h_lo_pt_reg});
            y1 = $signed({3'b000, h_hi_pt_reg});
            x0 = DIFF_W'($signed(h_lo_raw_reg));
            x1 = DIFF_W'($signed(h_hi_raw_reg));
        end
        d  = x1 - x0;
        xd = x - x0;
        dy = y1 - y0;
    end

    // stage 2: scaled numerator and denominator, then magnitudes
    always_comb
    begin
        base = BASE_W'(p1_reg) + BASE_W'(p2_reg);
        be   = NUM_W'(base);
        de   = NUM_W'(d1_reg);
        dd   = DEN_W'(d1_reg);
        if (kind1_reg == CMD_TEMP)
        begin
            num = (be <<< 11) + (be <<< 8) + (de <<< 18) + (de <<< 16);
            den = (dd <<< 5) + (dd <<< 3);
        end
        else
        begin
            num = be <<< 7;
            den = dd;
        end
        job_next.kind = kind1_reg;
        if (d1_reg == '0)
        begin
            job_next.err     = 1'b1;
            job_next.neg     = 1'b0;
            job_next.num_mag = '0;
            job_next.den_mag = DMAG_W'(1);
        end
        else
        begin
            job_next.err     = 1'b0;
            job_next.neg     = num[NUM_W-1] ^ den[DEN_W-1];
            job_next.num_mag = MAG_W'(num[NUM_W-1] ? -num : num);
            job_next.den_mag = DMAG_W'(den[DEN_W-1] ? -den : den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg <= s_tuser;
            d1_reg    <= d;
            p1_reg    <= dy * xd;
            p2_reg    <= y0 * d;
            job_reg   <= job_next;
        end
    end

endmodule

### hw/rtl/hutc_queue.sv
module hutc_queue #(
    parameter int DEPTH = hutc_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hutc_pkg::job_t         wdata,
    input  logic                   pop,
    output hutc_pkg::job_t         rdata,
    output hutc_pkg::queue_status_t status
);
    import hutc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/hutc_div.sv
module hutc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hutc_pkg::job_t              job,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic [1:0]                  m_tuser
);
    import hutc_pkg::*;

    typedef struct packed {
        job_t              job;
        logic [DMAG_W-1:0] rem;
    } div_stage_t;

    localparam int NS = MAG_W;

    div_stage_t        st_reg  [NS];
    div_stage_t        st_next [NS];
    logic [NS-1:0]     vld_reg;
    logic              adv;
    logic [MAG_W-1:0]  qmag;
    logic [OUT_W-1:0]  res_next;
    logic [23:0]       data_reg;
    logic [1:0]        user_reg;

    assign adv      = !m_tvalid || m_tready;
    assign pop      = adv && !q_empty;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // one quotient bit per stage, restoring
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            div_stage_t        src;
            logic [DMAG_W:0]   cat;
            logic              ge;
            if (k == 0)
            begin
                src.job = job;
                src.rem = '0;
            end
            else
            begin
                src = st_reg[k-1];
            end
            cat = {src.rem, src.job.num_mag[MAG_W-1]};
            ge  = (cat >= {1'b0, src.job.den_mag});
            st_next[k]             = src;
            st_next[k].rem         = DMAG_W'(ge ? cat - {1'b0, src.job.den_mag} : cat);
            st_next[k].job.num_mag = {src.job.num_mag[MAG_W-2:0], ge};
        end
    end

    always_comb
    begin
        qmag = st_reg[NS-1].job.num_mag;
        if (st_reg[NS-1].job.err)
            res_next = '0;
        else if (st_reg[NS-1].job.neg)
            res_next = (qmag > MAG_W'(Q8_MIN)) ? Q8_MIN : OUT_W'(-qmag);
        else
            res_next = (qmag > MAG_W'(Q8_MAX)) ? Q8_MAX : OUT_W'(qmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[NS-2:0], !q_empty};
            m_tvalid <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++)
                st_reg[k] <= st_next[k];
            data_reg <= res_next;
            user_reg <= {st_reg[NS-1].job.err, st_reg[NS-1].job.kind};
        end
    end

endmodule

### hw/rtl/humidity_temp_compensation.sv
// two-point calibration of raw temperature and humidity samples
// input stream s_*: one raw sample per request, tuser selects the quantity
// output stream m_*: one calibrated q8 reading per request, with kind and
// calibration error flags in tuser
// configuration: cfg_we writes cfg_data into the register at cfg_index,
// write only while no request is in flight
// throughput: one request per cycle, sustained while m_tready stays high
// datapath: the accepting edge loads the multiply stage, then one scale
// stage, one queue write, forty quotient stages (one bit per stage) and
// the output register
// a stalled receiver freezes the quotient pipeline; the queue then fills
// and s_tready falls once the queue and the scale stage are full
// reset clears all valid state and loads the calibration reset values;
// no clearing pass is needed
module humidity_temp_compensation #(
    parameter int QUEUE_DEPTH = hutc_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hutc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [hutc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // raw_sample
    input  logic                        s_tuser,  // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,  // reading_q8
    output logic [1:0]                  m_tuser   // kind, calib_error
);
    import hutc_pkg::*;

    job_t          push_job, pop_job;
    logic          push, pop;
    queue_status_t qstat;

    hutc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (qstat.full),
        .push      (push),
        .job       (push_job)
    );

    hutc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_job),
        .pop    (pop),
        .rdata  (pop_job),
        .status (qstat)
    );

    hutc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (pop_job),
        .q_empty  (qstat.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("calibration error with nonzero reading");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> qstat.full)
        else $error("input stalled while queue has room");

    a_pop_flow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty && (!m_tvalid || m_tready))
        else $error("queue popped while empty or stalled");

endmodule
